[rtl/bs2d_pkg.sv]
// bs2d_pkg: constants, payload types and register codes of the 2d binomial smoothing core
// no dependencies; imported by the channel interfaces and the core

package bs2d_pkg;

    localparam int MAX_ROW_LENGTH = 4096;
    localparam int LINE_AW        = $clog2(MAX_ROW_LENGTH);
    localparam int SAMPLE_W       = 32;
    localparam int HVAL_W         = SAMPLE_W + 2;
    localparam int ROW_LEN_W      = 13;
    localparam int ROW_CNT_W      = 16;
    localparam int COL_W          = 12;
    localparam int CFG_IDX_W      = 8;
    localparam int CFG_DATA_W     = 16;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [HVAL_W-1:0]   t_hval;
    typedef logic [COL_W-1:0]           t_col;
    typedef logic [ROW_CNT_W-1:0]       t_row;
    typedef logic [CFG_IDX_W-1:0]       t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0]      t_cfg_data;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_LENGTH = 8'd0,
        REG_ROW_COUNT  = 8'd1
    } t_reg_idx;

    // one horizontal result on its way to the line memory
    typedef struct packed {
        t_col  col;
        t_row  row;
        t_hval h;
        logic  has_prev;    // row above exists, a result is due
        logic  prev_first;  // row above is the first row, passes through
        logic  last_row;    // this row is the last one, emitted as well
        logic  col_last;    // last column of the row
    } t_event;

    // line memory entry: older row in the upper half, newer row below
    typedef struct packed {
        t_hval older;
        t_hval newer;
    } t_line_entry;

endpackage

[rtl/bs2d_if.sv]
// bs2d channel interfaces: sample input, smoothed output and register write channel
// depends on bs2d_pkg

interface bs2d_in_if;
    logic                valid;
    logic                ready;
    bs2d_pkg::t_sample   sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface bs2d_out_if;
    logic                valid;
    logic                ready;
    bs2d_pkg::t_sample   smoothed;
    bs2d_pkg::t_row      out_row;
    bs2d_pkg::t_col      out_column;
    logic                frame_end;

    modport source (output valid, output smoothed, output out_row, output out_column,
                    output frame_end, input ready);
    modport sink   (input valid, input smoothed, input out_row, input out_column,
                    input frame_end, output ready);
endinterface

interface bs2d_cfg_if;
    logic                valid;
    logic                ready;
    bs2d_pkg::t_cfg_idx  index;
    bs2d_pkg::t_cfg_data data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/binomial_smoothing_2d_core.sv]
// binomial_smoothing_2d_core: separable 1-2-1 smoothing of a 2d field, line memory based
// depends on bs2d_pkg and the interfaces in bs2d_if.sv
//
// usage
//   i_in carries one Q15.16 sample per transfer in raster order. o_out carries the
//   smoothed samples tagged with row and column; frame_end marks the last one of a field.
//   row j comes out while row j+1 streams in; the last row comes out interleaved with
//   the row before it. i_cfg writes row_length (index 0) and row_count (index 1); a
//   write to either restarts the field at row 0 column 0, a write to any other index
//   is ignored. write only while the core is idle.
//   a result passes the event stage and the memory stage into the output register after
//   the transfer of the sample that completes it.
//   throughput: one sample per cycle while the pipeline is not stalled; the last sample
//   of a row completes two columns, and the next sample waits until the second has left
//   the pending slot. the memory stage takes one column a cycle outside the last row;
//   during the last row each column gives two results over the one output register.
//   reset: position back to row 0 column 0, row_length 4096, row_count 2, pipeline empty.
//   the line memory holds no reset value; results use no entry the first row has not written.
//   a stall on o_out holds the output register; the event and memory stages keep their
//   contents, and i_in.ready drops once those stages are full.

module binomial_smoothing_2d_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bs2d_in_if.sink       i_in,
    bs2d_out_if.source    o_out,
    bs2d_cfg_if.sink      i_cfg
);
    import bs2d_pkg::*;

    // configuration
    logic [ROW_LEN_W-1:0] r_row_length;
    logic [ROW_CNT_W-1:0] r_row_count;
    t_col                 len_m1;     // effective row length minus one
    t_row                 cnt_m1;     // effective row count minus one
    logic                 cfg_wr;
    logic                 cfg_hit;    // write to a known register

    // raster position and sample history
    t_col    r_col;
    t_row    r_row;
    t_sample r_left;
    t_sample r_mid;
    t_col    n_col;
    t_row    n_row;

    // event stage and pending second event at a row end
    logic    r_a_v, n_a_v;
    t_event  r_a, n_a;
    logic    r_p_v, n_p_v;
    t_event  r_p, n_p;
    t_event  ev0, ev1;
    logic    ev0_v, ev1_v;
    t_hval   h_mid;

    // memory stage
    logic        r_b_v, n_b_v;
    t_event      r_b, n_b;
    logic        r_b_phase, n_b_phase;
    logic        r_fwd, n_fwd;
    t_line_entry r_fwd_data;
    t_line_entry r_rd;
    t_line_entry mem [MAX_ROW_LENGTH];
    t_hval       b_old;
    t_hval       b_new;

    // output register
    logic    r_out_v;
    t_sample r_out_smoothed;
    t_row    r_out_row;
    t_col    r_out_column;
    logic    r_out_end;

    // handshakes
    logic in_acc;
    logic in_ready;
    logic out_can;
    logic push;
    logic b_done;
    logic b_take;
    logic a_adv;
    logic slot_open;

    // result arithmetic
    logic signed [HVAL_W+2:0] sum_v;
    logic signed [HVAL_W:0]   rnd_new;
    logic signed [HVAL_W:0]   rnd_h;
    t_sample                  res_first;
    t_sample                  res_value;
    t_row                     res_row;
    logic                     res_end;

    // ---------------------------------------------------------------- configuration
    assign cfg_wr      = i_cfg.valid & i_cfg.ready;
    assign cfg_hit     = cfg_wr & (i_cfg.index inside {REG_ROW_LENGTH, REG_ROW_COUNT});
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_length <= ROW_LEN_W'(MAX_ROW_LENGTH);
            r_row_count  <= ROW_CNT_W'(2);
        end else if (cfg_wr) begin
            case (i_cfg.index)
                REG_ROW_LENGTH: r_row_length <= i_cfg.data[ROW_LEN_W-1:0];
                REG_ROW_COUNT:  r_row_count  <= i_cfg.data[ROW_CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // row length: zero acts as one, too long saturates to the line memory depth; a row count below two acts as two
    always_comb begin
        if (r_row_length == '0) begin
            len_m1 = '0;
        end else if (r_row_length > ROW_LEN_W'(MAX_ROW_LENGTH)) begin
            len_m1 = COL_W'(MAX_ROW_LENGTH - 1);
        end else begin
            len_m1 = COL_W'(r_row_length - ROW_LEN_W'(1));
        end
        cnt_m1 = (r_row_count < ROW_CNT_W'(2)) ? ROW_CNT_W'(1) : r_row_count - ROW_CNT_W'(1);
    end

    // ---------------------------------------------------------------- horizontal pass
    assign in_ready   = ~r_p_v & slot_open;
    assign i_in.ready = in_ready;
    assign in_acc     = i_in.valid & in_ready;

    // left + 2*middle + new sample, in quarter units of the sample
    assign h_mid = {{2{r_left[SAMPLE_W-1]}}, r_left}
                 + {r_mid[SAMPLE_W-1], r_mid, 1'b0}
                 + {{2{i_in.sample[SAMPLE_W-1]}}, i_in.sample};

    always_comb begin
        // column c-1 completes with this sample; the first column passes through
        ev0_v           = (r_col != '0);
        ev0.col         = r_col - COL_W'(1);
        ev0.row         = r_row;
        ev0.h           = (r_col == COL_W'(1)) ? {r_mid, 2'b00} : h_mid;
        ev0.has_prev    = (r_row != '0);
        ev0.prev_first  = (r_row == ROW_CNT_W'(1));
        ev0.last_row    = (r_row == cnt_m1);
        ev0.col_last    = (ev0.col == len_m1);
        // the last column passes through as well
        ev1_v           = (r_col == len_m1);
        ev1.col         = r_col;
        ev1.row         = r_row;
        ev1.h           = {i_in.sample, 2'b00};
        ev1.has_prev    = ev0.has_prev;
        ev1.prev_first  = ev0.prev_first;
        ev1.last_row    = ev0.last_row;
        ev1.col_last    = 1'b1;
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (cfg_hit) begin
            n_col = '0;
            n_row = '0;
        end else if (in_acc) begin
            if (r_col >= len_m1) begin
                n_col = '0;
                n_row = (r_row >= cnt_m1) ? '0 : r_row + ROW_CNT_W'(1);
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_left <= '0;
            r_mid  <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            if (in_acc) begin
                r_left <= r_mid;
                r_mid  <= i_in.sample;
            end
        end
    end

    // ---------------------------------------------------------------- event stage
    assign b_take    = ~r_b_v | b_done;
    assign a_adv     = r_a_v & b_take;
    assign slot_open = ~r_a_v | a_adv;

    always_comb begin
        n_a_v = r_a_v;
        n_a   = r_a;
        n_p_v = r_p_v;
        n_p   = r_p;
        if (slot_open) begin
            if (r_p_v) begin
                n_a_v = 1'b1;
                n_a   = r_p;
                n_p_v = 1'b0;
            end else if (in_acc && ev0_v) begin
                n_a_v = 1'b1;
                n_a   = ev0;
                n_p_v = ev1_v;
                n_p   = ev1;
            end else if (in_acc) begin
                n_a_v = ev1_v;
                n_a   = ev1;
            end else begin
                n_a_v = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_p_v <= 1'b0;
        end else begin
            r_a_v <= n_a_v;
            r_p_v <= n_p_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a <= n_a;
        r_p <= n_p;
    end

    // ---------------------------------------------------------------- line memory stage
    // entry read when the event enters; written back when it leaves
    assign b_old = r_fwd ? r_fwd_data.older : r_rd.older;
    assign b_new = r_fwd ? r_fwd_data.newer : r_rd.newer;

    always_ff @(posedge i_clk) begin
        if (b_done) begin
            mem[r_b.col] <= '{older: b_new, newer: r_b.h};
        end
        if (a_adv) begin
            r_rd <= mem[r_a.col];
        end
    end

    // one-column rows hit the same entry back to back: bypass the read-first memory
    always_comb begin
        n_fwd = r_fwd;
        n_b_v = r_b_v;
        n_b   = r_b;
        n_b_phase = r_b_phase;
        if (b_take) begin
            n_b_v     = r_a_v;
            n_b       = r_a;
            n_b_phase = 1'b0;
            n_fwd     = r_b_v & r_a_v & (r_b.col == r_a.col);
        end else if (push) begin
            n_b_phase = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v     <= 1'b0;
            r_b_phase <= 1'b0;
            r_fwd     <= 1'b0;
        end else begin
            r_b_v     <= n_b_v;
            r_b_phase <= n_b_phase;
            r_fwd     <= n_fwd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b <= n_b;
        if (b_take) begin
            r_fwd_data <= '{older: b_new, newer: r_b.h};
        end
    end

    // ---------------------------------------------------------------- vertical pass
    // (older + 2*newer + h + 8) >> 4, floors, so rounding is half up
    assign sum_v   = {{3{b_old[HVAL_W-1]}}, b_old}
                   + {{2{b_new[HVAL_W-1]}}, b_new, 1'b0}
                   + {{3{r_b.h[HVAL_W-1]}}, r_b.h}
                   + (HVAL_W+3)'(8);
    assign rnd_new = {b_new[HVAL_W-1], b_new} + (HVAL_W+1)'(2);
    assign rnd_h   = {r_b.h[HVAL_W-1], r_b.h} + (HVAL_W+1)'(2);

    always_comb begin
        res_first = r_b.prev_first ? rnd_new[HVAL_W-1:2] : sum_v[HVAL_W+1:4];
        if (r_b_phase) begin
            // last row itself, behind the row above
            res_value = rnd_h[HVAL_W-1:2];
            res_row   = r_b.row;
            res_end   = r_b.col_last;
        end else begin
            res_value = res_first;
            res_row   = r_b.row - ROW_CNT_W'(1);
            res_end   = 1'b0;
        end
    end

    assign out_can = ~r_out_v | o_out.ready;
    assign push    = r_b_v & r_b.has_prev & out_can;
    assign b_done  = r_b_v & (~r_b.has_prev | (push & (r_b_phase | ~r_b.last_row)));

    // ---------------------------------------------------------------- output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (push) begin
            r_out_v <= 1'b1;
        end else if (o_out.ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_out_smoothed <= res_value;
            r_out_row      <= res_row;
            r_out_column   <= r_b.col;
            r_out_end      <= res_end;
        end
    end

    assign o_out.valid      = r_out_v;
    assign o_out.smoothed   = r_out_smoothed;
    assign o_out.out_row    = r_out_row;
    assign o_out.out_column = r_out_column;
    assign o_out.frame_end  = r_out_end;

    // ---------------------------------------------------------------- checks
    // a pending row-end event always sits behind an occupied event slot
    a_pend_behind_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p_v |-> r_a_v)
        else $error("pending event without event in the slot ahead");

    // bypass only ever feeds an event that is in the memory stage
    a_fwd_with_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd |-> r_b_v)
        else $error("bypass flag set with memory stage empty");

    // second result phase only for the last row
    a_phase_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_phase |-> (r_b_v && r_b.last_row && r_b.has_prev))
        else $error("second result phase outside the last row");

    // an unfinished event stays put, with its column
    a_b_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_v && !b_done) |=> (r_b_v && $stable(r_b.col)))
        else $error("memory stage event lost before completion");

    // a result pushed while the output is blocked would overwrite it
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !o_out.ready) |-> !push)
        else $error("output register overwritten while stalled");

endmodule
